FILE: rtl/core/pmqm_pkg.sv
package pmqm_pkg;

  localparam int POOL_DEPTH  = 64;
  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_W      = $clog2(POOL_DEPTH);
  localparam int ENT_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PID_W       = 16;
  localparam int KIND_W      = 4;
  localparam int ARG_W       = 16;
  localparam int PAY_W       = 4 * ARG_W;

  typedef enum logic [0:0] {
    FUNC_POST  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_POSTED     = 3'd0,
    ST_POOL_FULL  = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_FETCHED    = 3'd3,
    ST_NONE       = 3'd4
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_POP,
    S_RESP
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic exec;
    logic pop;
    logic load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic fetch_hit;
  } sts_t;

  // Lowest set bit of a pool-wide vector.
  function automatic logic [SLOT_W-1:0] low_set_pool(input logic [POOL_DEPTH-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) r = SLOT_W'(i);
    end
    return r;
  endfunction

  // Lowest set bit of a table-wide vector.
  function automatic logic [ENT_W-1:0] low_set_ent(input logic [TABLE_DEPTH-1:0] v);
    logic [ENT_W-1:0] r;
    r = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) r = ENT_W'(i);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/per_process_message_queue_manager_unit.sv
// Message queue manager: a shared pool of POOL_DEPTH message slots holds one FIFO per
// process id as a linked list, tracked by a table of TABLE_DEPTH open queues (owner pid,
// head, tail). A post (func 0) stores type and four words in the lowest free slot and
// appends it to the pid's queue, opening a queue in the lowest free table entry if needed;
// it reports pool full or table full and then changes nothing. A fetch (func 1) returns and
// frees the oldest message of the pid, or reports nothing waiting. One transaction is worked
// at a time: a result reaches the result register through the owner match on the accepting
// edge, the registered read of the head/tail tables, the update step and, for a fetch that
// finds a message, the registered read of the slot memory. The input is stalled from
// acceptance until the transaction leaves its last state, so no new transaction is taken
// while one is worked. A result waiting under out_stall_i does not hold off the next
// acceptance; that transaction then waits in its last state, with the input stalled, until
// the waiting result leaves. No initialization pass is needed after reset.
module per_process_message_queue_manager_unit
  import pmqm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic [PID_W-1:0]         pid_i,
  input  logic [KIND_W-1:0]        msg_type_i,
  input  logic signed [ARG_W-1:0]  arg0_i,
  input  logic signed [ARG_W-1:0]  arg1_i,
  input  logic signed [ARG_W-1:0]  arg2_i,
  input  logic signed [ARG_W-1:0]  arg3_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [KIND_W-1:0]        out_type_o,
  output logic signed [ARG_W-1:0]  out_arg0_o,
  output logic signed [ARG_W-1:0]  out_arg1_o,
  output logic signed [ARG_W-1:0]  out_arg2_o,
  output logic signed [ARG_W-1:0]  out_arg3_o
);

  cmd_t cmd;
  sts_t sts;

  pmqm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pmqm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .func_i     (func_i),
    .pid_i      (pid_i),
    .msg_type_i (msg_type_i),
    .arg0_i     (arg0_i),
    .arg1_i     (arg1_i),
    .arg2_i     (arg2_i),
    .arg3_i     (arg3_i),
    .status_o   (status_o),
    .out_type_o (out_type_o),
    .out_arg0_o (out_arg0_o),
    .out_arg1_o (out_arg1_o),
    .out_arg2_o (out_arg2_o),
    .out_arg3_o (out_arg3_o)
  );

endmodule

FILE: rtl/core/pmqm_ctrl.sv
module pmqm_ctrl
  import pmqm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_LOOK;
      S_LOOK: state_d = S_EXEC;
      S_EXEC: state_d = sts_i.fetch_hit ? S_POP : S_RESP;
      S_POP:  state_d = S_RESP;
      S_RESP: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: cmd_o.capture = in_valid_i;
      S_LOOK: cmd_o.lookup = 1'b1;
      S_EXEC: cmd_o.exec = 1'b1;
      S_POP:  cmd_o.pop = 1'b1;
      S_RESP: cmd_o.load_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/pmqm_dp.sv
module pmqm_dp
  import pmqm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic                     func_i,
  input  logic [PID_W-1:0]         pid_i,
  input  logic [KIND_W-1:0]        msg_type_i,
  input  logic signed [ARG_W-1:0]  arg0_i,
  input  logic signed [ARG_W-1:0]  arg1_i,
  input  logic signed [ARG_W-1:0]  arg2_i,
  input  logic signed [ARG_W-1:0]  arg3_i,
  output logic [2:0]               status_o,
  output logic [KIND_W-1:0]        out_type_o,
  output logic signed [ARG_W-1:0]  out_arg0_o,
  output logic signed [ARG_W-1:0]  out_arg1_o,
  output logic signed [ARG_W-1:0]  out_arg2_o,
  output logic signed [ARG_W-1:0]  out_arg3_o
);

  // Captured transaction.
  func_e               func_q;
  logic [PID_W-1:0]    pid_q;
  logic [KIND_W-1:0]   kind_q;
  logic [PAY_W-1:0]    pay_q;
  logic [TABLE_DEPTH-1:0] match_q, match_d;

  // Occupancy and owner cells.
  logic [POOL_DEPTH-1:0]  slot_valid_q, slot_valid_d;
  logic [TABLE_DEPTH-1:0] entry_used_q, entry_used_d;
  logic [PID_W-1:0]       entry_owner_q [TABLE_DEPTH];

  // Lookup results.
  logic [ENT_W-1:0]  ent_q, free_ent_q, ent_sel;
  logic [SLOT_W-1:0] slot_q;
  logic              hit_q, pool_full_q, table_full_q;

  // Memories and their registered read data.
  logic [SLOT_W-1:0]        head_mem [TABLE_DEPTH];
  logic [SLOT_W-1:0]        tail_mem [TABLE_DEPTH];
  logic [KIND_W+PAY_W-1:0]  data_mem [POOL_DEPTH];
  logic [SLOT_W-1:0]        link_mem [POOL_DEPTH];
  logic [SLOT_W-1:0]        head_rd_q, tail_rd_q, link_rd_q;
  logic [KIND_W+PAY_W-1:0]  data_rd_q;

  // Result and output registers.
  stat_e              res_status_q, status_d;
  logic [KIND_W-1:0]  res_kind_q, out_kind_q;
  logic [PAY_W-1:0]   res_pay_q, out_pay_q;
  stat_e              out_status_q;

  logic post_ok, post_new;
  logic head_we;
  logic [ENT_W-1:0]  head_wa;
  logic [SLOT_W-1:0] head_wd;

  always_comb begin
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      match_d[e] = entry_used_q[e] && (entry_owner_q[e] == pid_i);
    end
  end

  assign ent_sel = low_set_ent(match_q);

  always_comb begin
    if (func_q == FUNC_POST) begin
      if (pool_full_q)                status_d = ST_POOL_FULL;
      else if (!hit_q && table_full_q) status_d = ST_TABLE_FULL;
      else                             status_d = ST_POSTED;
    end else begin
      status_d = hit_q ? ST_FETCHED : ST_NONE;
    end
  end

  assign post_ok  = cmd_i.exec && (status_d == ST_POSTED);
  assign post_new = post_ok && !hit_q;

  // Head table has two writers: opening a list and advancing on a pop.
  always_comb begin
    head_we = 1'b0;
    head_wa = ent_q;
    head_wd = link_rd_q;
    if (post_new) begin
      head_we = 1'b1;
      head_wa = free_ent_q;
      head_wd = slot_q;
    end else if (cmd_i.pop && (head_rd_q != tail_rd_q)) begin
      head_we = 1'b1;
    end
  end

  always_comb begin
    slot_valid_d = slot_valid_q;
    entry_used_d = entry_used_q;
    if (post_ok) slot_valid_d[slot_q] = 1'b1;
    if (post_new) entry_used_d[free_ent_q] = 1'b1;
    if (cmd_i.pop) begin
      slot_valid_d[head_rd_q] = 1'b0;
      // Close the list when its last message leaves.
      if (head_rd_q == tail_rd_q) entry_used_d[ent_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      entry_used_q <= '0;
    end else begin
      slot_valid_q <= slot_valid_d;
      entry_used_q <= entry_used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_e'(func_i);
      pid_q   <= pid_i;
      kind_q  <= msg_type_i;
      pay_q   <= {arg3_i, arg2_i, arg1_i, arg0_i};
      match_q <= match_d;
    end
    if (cmd_i.lookup) begin
      ent_q        <= ent_sel;
      hit_q        <= |match_q;
      slot_q       <= low_set_pool(~slot_valid_q);
      pool_full_q  <= &slot_valid_q;
      free_ent_q   <= low_set_ent(~entry_used_q);
      table_full_q <= &entry_used_q;
    end
    if (post_new) entry_owner_q[free_ent_q] <= pid_q;
    if (cmd_i.exec) begin
      res_status_q <= status_d;
      res_kind_q   <= '0;
      res_pay_q    <= '0;
    end
    if (cmd_i.pop) begin
      res_kind_q <= data_rd_q[KIND_W+PAY_W-1:PAY_W];
      res_pay_q  <= data_rd_q[PAY_W-1:0];
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_kind_q   <= res_kind_q;
      out_pay_q    <= res_pay_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (cmd_i.lookup) head_rd_q <= head_mem[ent_sel];
  end

  always_ff @(posedge clk_i) begin
    if (post_ok) tail_mem[hit_q ? ent_q : free_ent_q] <= slot_q;
    if (cmd_i.lookup) tail_rd_q <= tail_mem[ent_sel];
  end

  always_ff @(posedge clk_i) begin
    if (post_ok) data_mem[slot_q] <= {kind_q, pay_q};
    if (cmd_i.exec) data_rd_q <= data_mem[head_rd_q];
  end

  // Chain the new slot behind the current tail.
  always_ff @(posedge clk_i) begin
    if (post_ok && hit_q) link_mem[tail_rd_q] <= slot_q;
    if (cmd_i.exec) link_rd_q <= link_mem[head_rd_q];
  end

  assign sts_o.fetch_hit = (func_q == FUNC_FETCH) && hit_q;

  assign status_o   = out_status_q;
  assign out_type_o = out_kind_q;
  assign out_arg0_o = out_pay_q[ARG_W-1:0];
  assign out_arg1_o = out_pay_q[2*ARG_W-1:ARG_W];
  assign out_arg2_o = out_pay_q[3*ARG_W-1:2*ARG_W];
  assign out_arg3_o = out_pay_q[4*ARG_W-1:3*ARG_W];

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  import pmqm_pkg::*;

  typedef struct packed {
    func_e              func;
    logic [PID_W-1:0]   pid;
    logic [KIND_W-1:0]  kind;
    logic [ARG_W-1:0]   arg0;
    logic [ARG_W-1:0]   arg1;
    logic [ARG_W-1:0]   arg2;
    logic [ARG_W-1:0]   arg3;
  } request_t;

  typedef struct packed {
    stat_e              status;
    logic [KIND_W-1:0]  kind;
    logic [ARG_W-1:0]   arg0;
    logic [ARG_W-1:0]   arg1;
    logic [ARG_W-1:0]   arg2;
    logic [ARG_W-1:0]   arg3;
  } reply_t;

  typedef struct packed {
    logic      typed;
    request_t  req;
    reply_t    rep;
  } row_t;

  localparam reply_t R_ANY    = '0;
  localparam reply_t R_POSTED = '{ST_POSTED, '0, '0, '0, '0, '0};
  localparam reply_t R_NONE   = '{ST_NONE, '0, '0, '0, '0, '0};

  localparam int N_DIRECTED = 18;
  localparam int N_RANDOM   = 1800;
  localparam int CROWD_MAX  = 48;

  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{1'b1, '{FUNC_FETCH, 16'h0000, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, R_NONE},
    '{1'b1, '{FUNC_FETCH, 16'hFFFF, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, R_NONE},
    '{1'b1, '{FUNC_POST, 16'h0000, 4'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, R_POSTED},
    '{1'b1, '{FUNC_POST, 16'hFFFF, 4'hF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, R_POSTED},
    '{1'b1, '{FUNC_POST, 16'h0000, 4'hA, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA}, R_POSTED},
    '{1'b1, '{FUNC_POST, 16'h1234, 4'h3, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, R_POSTED},
    '{1'b1, '{FUNC_FETCH, 16'h0000, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{ST_FETCHED, 4'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000}},
    '{1'b0, '{FUNC_POST, 16'h0000, 4'h6, 16'h0123, 16'h4567, 16'h89AB, 16'hCDEF}, R_ANY},
    '{1'b1, '{FUNC_FETCH, 16'h0000, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{ST_FETCHED, 4'hA, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA}},
    '{1'b0, '{FUNC_FETCH, 16'h0000, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, R_ANY},
    // queue of pid 0 was closed by its last message
    '{1'b1, '{FUNC_FETCH, 16'h0000, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, R_NONE},
    '{1'b1, '{FUNC_FETCH, 16'hFFFF, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{ST_FETCHED, 4'hF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}},
    '{1'b1, '{FUNC_FETCH, 16'h1234, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{ST_FETCHED, 4'h3, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
    '{1'b1, '{FUNC_FETCH, 16'h1234, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, R_NONE},
    '{1'b0, '{FUNC_POST, 16'h5A5A, 4'hC, 16'h1357, 16'h2468, 16'h9ACE, 16'hBDF0}, R_ANY},
    '{1'b0, '{FUNC_POST, 16'hA5A5, 4'h5, 16'hFEDC, 16'hBA98, 16'h7654, 16'h3210}, R_ANY},
    '{1'b0, '{FUNC_FETCH, 16'h5A5A, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, R_ANY},
    '{1'b0, '{FUNC_FETCH, 16'hA5A5, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, R_ANY}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              func_in = 1'b0;
  logic [PID_W-1:0]  pid_in = '0;
  logic [KIND_W-1:0] kind_in = '0;
  logic [ARG_W-1:0]  arg0_in = '0;
  logic [ARG_W-1:0]  arg1_in = '0;
  logic [ARG_W-1:0]  arg2_in = '0;
  logic [ARG_W-1:0]  arg3_in = '0;
  logic              out_stall = 1'b0;
  logic              steady = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic [2:0]        status_out;
  logic [KIND_W-1:0] kind_out;
  logic [ARG_W-1:0]  arg0_out;
  logic [ARG_W-1:0]  arg1_out;
  logic [ARG_W-1:0]  arg2_out;
  logic [ARG_W-1:0]  arg3_out;

  // Shadow of the slot pool and the queue table.
  bit                  slot_busy  [POOL_DEPTH];
  logic [KIND_W-1:0]   slot_kind  [POOL_DEPTH];
  logic [4*ARG_W-1:0]  slot_words [POOL_DEPTH];
  logic [SLOT_W-1:0]   slot_next  [POOL_DEPTH];
  bit                  q_open     [TABLE_DEPTH];
  logic [PID_W-1:0]    q_owner    [TABLE_DEPTH];
  logic [SLOT_W-1:0]   q_head     [TABLE_DEPTH];
  logic [SLOT_W-1:0]   q_tail     [TABLE_DEPTH];

  reply_t            awaited_replies [$];
  int                mismatches = 0;
  logic [PID_W-1:0]  crowd [CROWD_MAX];
  int                crowd_size = 1;

  per_process_message_queue_manager_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .func_i      (func_in),
    .pid_i       (pid_in),
    .msg_type_i  (kind_in),
    .arg0_i      (arg0_in),
    .arg1_i      (arg1_in),
    .arg2_i      (arg2_in),
    .arg3_i      (arg3_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status_out),
    .out_type_o  (kind_out),
    .out_arg0_o  (arg0_out),
    .out_arg1_o  (arg1_out),
    .out_arg2_o  (arg2_out),
    .out_arg3_o  (arg3_out)
  );

  always #4 clk = ~clk;

  function automatic int queue_of(input logic [PID_W-1:0] pid);
    int q;
    q = -1;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (q_open[i] && q_owner[i] == pid) q = i;
    end
    return q;
  endfunction

  // Apply one transaction to the shadow state and return its reply.
  function automatic reply_t serve_request(input request_t r);
    reply_t rep;
    int     slot;
    int     q;
    int     free_q;
    rep = R_POSTED;
    slot = -1;
    free_q = -1;
    q = queue_of(r.pid);
    if (r.func == FUNC_POST) begin
      for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
        if (!slot_busy[i]) slot = i;
      end
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
        if (!q_open[i]) free_q = i;
      end
      if (slot < 0) begin
        rep.status = ST_POOL_FULL;
      end else if (q < 0 && free_q < 0) begin
        rep.status = ST_TABLE_FULL;
      end else begin
        if (q < 0) begin
          q = free_q;
          q_open[q]  = 1'b1;
          q_owner[q] = r.pid;
          q_head[q]  = SLOT_W'(slot);
        end else begin
          slot_next[q_tail[q]] = SLOT_W'(slot);
        end
        q_tail[q]        = SLOT_W'(slot);
        slot_busy[slot]  = 1'b1;
        slot_kind[slot]  = r.kind;
        slot_words[slot] = {r.arg3, r.arg2, r.arg1, r.arg0};
      end
    end else if (q < 0) begin
      rep.status = ST_NONE;
    end else begin
      slot = q_head[q];
      rep.status = ST_FETCHED;
      rep.kind   = slot_kind[slot];
      {rep.arg3, rep.arg2, rep.arg1, rep.arg0} = slot_words[slot];
      if (q_head[q] == q_tail[q]) q_open[q] = 1'b0;
      else q_head[q] = slot_next[slot];
      slot_busy[slot] = 1'b0;
    end
    return rep;
  endfunction

  function automatic request_t random_request(input int post_pct);
    request_t r;
    r.func = ($urandom_range(99) < post_pct) ? FUNC_POST : FUNC_FETCH;
    if ($urandom_range(9) == 0) r.pid = PID_W'($urandom);
    else r.pid = crowd[$urandom_range(crowd_size - 1)];
    r.kind = KIND_W'($urandom);
    r.arg0 = ARG_W'($urandom);
    r.arg1 = ARG_W'($urandom);
    r.arg2 = ARG_W'($urandom);
    r.arg3 = ARG_W'($urandom);
    return r;
  endfunction

  // Pick the set of pids that one phase mostly talks to.
  task automatic pick_crowd();
    crowd_size = ($urandom_range(3) == 0) ? $urandom_range(20, CROWD_MAX)
                                          : $urandom_range(1, 6);
    for (int k = 0; k < CROWD_MAX; k++) begin
      if ($urandom_range(7) == 0) crowd[k] = $urandom_range(1) ? '1 : '0;
      else crowd[k] = PID_W'($urandom);
    end
  endtask

  task automatic send_request(input request_t r, input logic typed, input reply_t typed_rep);
    reply_t pred;
    if (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!steady && $urandom_range(99) < 38) @(posedge clk);
    end
    in_valid <= 1'b1;
    func_in  <= r.func;
    pid_in   <= r.pid;
    kind_in  <= r.kind;
    arg0_in  <= r.arg0;
    arg1_in  <= r.arg1;
    arg2_in  <= r.arg2;
    arg3_in  <= r.arg3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = serve_request(r);
    awaited_replies.push_back(typed ? typed_rep : pred);
  endtask

  always @(posedge clk) begin : take_reply
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply with no transaction pending: status=%0d type=%0d", status_out,
                   kind_out);
      end else begin
        want = awaited_replies.pop_front();
        if (status_out !== want.status || kind_out !== want.kind ||
            arg0_out !== want.arg0 || arg1_out !== want.arg1 ||
            arg2_out !== want.arg2 || arg3_out !== want.arg3) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch: expected status=%0d type=%0d args=%0d %0d %0d %0d, ",
                   want.status, want.kind, $signed(want.arg0), $signed(want.arg1),
                   $signed(want.arg2), $signed(want.arg3));
            $display("got status=%0d type=%0d args=%0d %0d %0d %0d",
                     status_out, kind_out, $signed(arg0_out), $signed(arg1_out),
                     $signed(arg2_out), $signed(arg3_out));
          end
        end
      end
    end
    out_stall <= !steady && ($urandom_range(99) < 38);
  end

  initial begin
    #3200000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    int phase_left;
    int post_pct;
    phase_left = 0;
    post_pct = 50;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++)
      send_request(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].rep);

    // Alternate fill, drain and mixed phases so the pool runs full and empty
    // again. The table cannot fill at these depths: each open queue holds a slot.
    pick_crowd();
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 700) steady <= 1'b1;
      if (n == 1000) steady <= 1'b0;
      if (phase_left == 0) begin
        phase_left = $urandom_range(60, 160);
        case ($urandom_range(3))
          0:       post_pct = 85;
          1:       post_pct = 20;
          2:       post_pct = 50;
          default: post_pct = 65;
        endcase
        if ($urandom_range(1) == 0) pick_crowd();
      end
      phase_left--;
      send_request(random_request(post_pct), 1'b0, R_ANY);
    end
    in_valid <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: per_process_message_queue_manager_unit.f
rtl/core/pmqm_pkg.sv
rtl/core/pmqm_ctrl.sv
rtl/core/pmqm_dp.sv
rtl/core/per_process_message_queue_manager_unit.sv
tb/sv/testbench.sv
